// ===== sv/sts_pkg.sv =====
`timescale 1ns / 1ps
package sts_pkg;

  localparam int CAPACITY      = 256;
  localparam int PRIORITY_BITS = 32;

  localparam int SUM_BITS   = 40;
  localparam int SLOT_BITS  = 8;
  localparam int PRIO_W     = 32;
  localparam int LEAF_BITS  = $clog2(CAPACITY);
  localparam int NODE_COUNT = 2 * CAPACITY - 1;
  localparam int NODE_BITS  = $clog2(NODE_COUNT);
  localparam int LEAF_BASE  = CAPACITY - 1;

  // priority field kept to its low PRIORITY_BITS bits
  localparam logic [PRIO_W-1:0] PRIO_MASK = (PRIORITY_BITS >= PRIO_W) ?
      {PRIO_W{1'b1}} : PRIO_W'((64'd1 << PRIORITY_BITS) - 64'd1);

  localparam logic [NODE_BITS-1:0] LEAF_BASE_N = NODE_BITS'(LEAF_BASE);
  localparam logic [NODE_BITS-1:0] LAST_NODE_N = NODE_BITS'(NODE_COUNT - 1);

  localparam logic ACT_UPDATE   = 1'b0;
  localparam logic ACT_RETRIEVE = 1'b1;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_U_READ,
    ST_U_LEAF,
    ST_U_ANC,
    ST_R_ROOT,
    ST_R_TOT,
    ST_R_DESC,
    ST_R_LEAF,
    ST_OUT
  } sts_state_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_CLEAR,
    OP_LATCH,
    OP_U_READ,
    OP_U_LEAF,
    OP_U_ANC,
    OP_R_ROOT,
    OP_R_TOT,
    OP_R_DESC,
    OP_R_LEAF
  } sts_op_t;

  typedef struct packed {
    sts_op_t op;
  } sts_cmd_t;

  typedef struct packed {
    logic clr_done;   // clearing pass is at the last node
    logic at_root;    // ancestor walk is at node 0
    logic desc_leaf;  // descent step lands on a leaf
    logic retrieve;   // latched word is a retrieve
  } sts_stat_t;

endpackage

// ===== sv/sts_if.sv =====
`timescale 1ns / 1ps
interface sts_in_if;
  import sts_pkg::*;

  logic                 valid;
  logic                 ready;
  logic                 action;
  logic [SLOT_BITS-1:0] slot;
  logic [PRIO_W-1:0]    new_priority;
  logic [SUM_BITS-1:0]  query_value;

  modport source (output valid, action, slot, new_priority, query_value, input ready);
  modport sink   (input valid, action, slot, new_priority, query_value, output ready);
endinterface

interface sts_out_if;
  import sts_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [SLOT_BITS-1:0] leaf_index;
  logic [PRIO_W-1:0]    leaf_priority;
  logic [SUM_BITS-1:0]  total_priority;

  modport source (output valid, leaf_index, leaf_priority, total_priority, input ready);
  modport sink   (input valid, leaf_index, leaf_priority, total_priority, output ready);
endinterface

// ===== sv/sts_ram.sv =====
`timescale 1ns / 1ps
module sts_ram #(
  parameter int WIDTH = 40,
  parameter int DEPTH = 511
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;
endmodule

// ===== sv/sts_ctrl.sv =====
`timescale 1ns / 1ps
module sts_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  sts_pkg::sts_stat_t stat,
  output sts_pkg::sts_cmd_t  cmd
);
  import sts_pkg::*;

  sts_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd.op    = OP_NONE;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    case (state_r)
      ST_CLEAR: begin
        cmd.op = OP_CLEAR;
        if (stat.clr_done) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op    = OP_LATCH;
          state_nxt = ST_U_READ;
        end
      end
      ST_U_READ: begin
        // latched word decides which walk runs
        if (stat.retrieve) begin
          state_nxt = ST_R_ROOT;
        end else begin
          cmd.op    = OP_U_READ;
          state_nxt = ST_U_LEAF;
        end
      end
      ST_U_LEAF: begin
        cmd.op    = OP_U_LEAF;
        state_nxt = ST_U_ANC;
      end
      ST_U_ANC: begin
        cmd.op = OP_U_ANC;
        if (stat.at_root) state_nxt = ST_OUT;
      end
      ST_R_ROOT: begin
        cmd.op    = OP_R_ROOT;
        state_nxt = ST_R_TOT;
      end
      ST_R_TOT: begin
        cmd.op    = OP_R_TOT;
        state_nxt = ST_R_DESC;
      end
      ST_R_DESC: begin
        cmd.op = OP_R_DESC;
        if (stat.desc_leaf) state_nxt = ST_R_LEAF;
      end
      ST_R_LEAF: begin
        cmd.op    = OP_R_LEAF;
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        out_valid = 1'b1;
        if (out_ready) state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end
endmodule

// ===== sv/sts_dp.sv =====
`timescale 1ns / 1ps
module sts_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  sts_pkg::sts_cmd_t             cmd,
  output sts_pkg::sts_stat_t            stat,
  input  logic                          action,
  input  logic [sts_pkg::SLOT_BITS-1:0] slot,
  input  logic [sts_pkg::PRIO_W-1:0]    new_priority,
  input  logic [sts_pkg::SUM_BITS-1:0]  query_value,
  output logic [sts_pkg::SLOT_BITS-1:0] leaf_index,
  output logic [sts_pkg::PRIO_W-1:0]    leaf_priority,
  output logic [sts_pkg::SUM_BITS-1:0]  total_priority
);
  import sts_pkg::*;

  logic [NODE_BITS-1:0] node_r, node_nxt;
  logic                 retr_r;
  logic [LEAF_BITS-1:0] leaf_r;
  logic [SUM_BITS-1:0]  p_r, v_r, diff_r, total_r;
  logic [PRIO_W-1:0]    prio_r;

  logic                 we, re;
  logic [NODE_BITS-1:0] waddr, raddr;
  logic [SUM_BITS-1:0]  wdata, rdata;

  logic [NODE_BITS-1:0] parent, left_n, desc_n;
  logic [SUM_BITS-1:0]  anc_sum;
  logic                 go_left, desc_is_leaf;
  logic [LEAF_BITS-1:0] in_leaf;

  sts_ram #(.WIDTH(SUM_BITS), .DEPTH(NODE_COUNT)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign in_leaf      = LEAF_BITS'(slot);
  assign parent       = NODE_BITS'((node_r - NODE_BITS'(1)) >> 1);
  assign left_n       = NODE_BITS'({node_r, 1'b1});
  assign anc_sum      = rdata + diff_r;
  assign go_left      = (v_r <= rdata);
  assign desc_n       = go_left ? left_n : left_n + NODE_BITS'(1);
  assign desc_is_leaf = (desc_n >= LEAF_BASE_N);

  assign stat.clr_done  = (node_r == LAST_NODE_N);
  assign stat.at_root   = (node_r == '0);
  assign stat.desc_leaf = desc_is_leaf;
  assign stat.retrieve  = retr_r;

  always_comb begin
    we       = 1'b0;
    re       = 1'b0;
    waddr    = node_r;
    wdata    = '0;
    raddr    = node_r;
    node_nxt = node_r;
    case (cmd.op)
      OP_CLEAR: begin
        we       = 1'b1;
        node_nxt = node_r + NODE_BITS'(1);
      end
      OP_LATCH: begin
        node_nxt = LEAF_BASE_N + NODE_BITS'(in_leaf);
      end
      OP_U_READ: begin
        re = 1'b1;
      end
      OP_U_LEAF: begin
        we       = 1'b1;
        wdata    = p_r;
        re       = 1'b1;
        raddr    = parent;
        node_nxt = parent;
      end
      OP_U_ANC: begin
        we    = 1'b1;
        wdata = anc_sum;
        if (node_r != '0) begin
          re       = 1'b1;
          raddr    = parent;
          node_nxt = parent;
        end
      end
      OP_R_ROOT: begin
        re       = 1'b1;
        raddr    = '0;
        node_nxt = '0;
      end
      OP_R_TOT: begin
        re    = 1'b1;
        raddr = left_n;
      end
      OP_R_DESC: begin
        re       = 1'b1;
        raddr    = desc_is_leaf ? desc_n : NODE_BITS'({desc_n, 1'b1});
        node_nxt = desc_n;
      end
      default: begin
      end
    endcase
  end

  // node pointer doubles as the clearing counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_r <= '0;
      retr_r <= 1'b0;
    end else begin
      node_r <= node_nxt;
      if (cmd.op == OP_LATCH) retr_r <= (action == ACT_RETRIEVE);
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LATCH: begin
        leaf_r <= in_leaf;
        p_r    <= SUM_BITS'(new_priority & PRIO_MASK);
        v_r    <= query_value;
      end
      OP_U_LEAF: begin
        diff_r <= p_r - rdata;
        prio_r <= PRIO_W'(p_r);
      end
      OP_U_ANC: begin
        if (node_r == '0) total_r <= anc_sum;
      end
      OP_R_TOT: begin
        total_r <= rdata;
      end
      OP_R_DESC: begin
        if (!go_left) v_r <= v_r - rdata;
      end
      OP_R_LEAF: begin
        prio_r <= PRIO_W'(rdata);
        leaf_r <= LEAF_BITS'(node_r - LEAF_BASE_N);
      end
      default: begin
      end
    endcase
  end

  assign leaf_index     = SLOT_BITS'(leaf_r);
  assign leaf_priority  = prio_r;
  assign total_priority = total_r;
endmodule

// ===== sv/sum_tree_priority_sampler_unit.sv =====
`timescale 1ns / 1ps
// Each word walks the tree one node per cycle, from the accepting edge to out
//   valid, on the node RAM with its separate read and write ports.
// One word at a time: a new word is taken only after the last result is accepted.
// Reset (rst_n low, synchronous): clearing pass zeroes all 2*CAPACITY-1 = 511
//   nodes, one per cycle; in ready stays low until it finishes.
module sum_tree_priority_sampler_unit (
  input logic      clk,
  input logic      rst_n,
  sts_in_if.sink   in_ch,
  sts_out_if.source out_ch
);
  import sts_pkg::*;

  // controller <-> datapath
  sts_cmd_t  cmd;
  sts_stat_t stat;

  // Controller: clear pass, then per word either
  //   update   - read leaf, write new leaf and keep the delta, then walk
  //              parents adding the delta (write node, read parent each cycle)
  //   retrieve - read root for the total, then descend one level a cycle,
  //              reading the next left child while the compare settles
  sts_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Datapath: node RAM, walk pointer, query residue, delta and result regs.
  // Result regs hold steady while out valid waits for ready.
  sts_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .stat           (stat),
    .action         (in_ch.action),
    .slot           (in_ch.slot),
    .new_priority   (in_ch.new_priority),
    .query_value    (in_ch.query_value),
    .leaf_index     (out_ch.leaf_index),
    .leaf_priority  (out_ch.leaf_priority),
    .total_priority (out_ch.total_priority)
  );
endmodule

// ===== sv/sts_checker.sv =====
`timescale 1ns / 1ps
module sts_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [sts_pkg::SLOT_BITS-1:0] leaf_index,
  input logic [sts_pkg::PRIO_W-1:0]    leaf_priority,
  input logic [sts_pkg::SUM_BITS-1:0]  total_priority
);
  import sts_pkg::*;

  // a stalled result word stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("out valid dropped while stalled");

  // one word in flight: never take input while a result is offered
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input ready while result pending");

  // after accepting a word the unit is busy
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input ready straight after accept");

  // one result per word
  a_single_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready |=> !out_valid)
    else $error("result repeated");
endmodule

bind sum_tree_priority_sampler_unit sts_checker u_sts_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_ch.valid),
  .in_ready       (in_ch.ready),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .leaf_index     (out_ch.leaf_index),
  .leaf_priority  (out_ch.leaf_priority),
  .total_priority (out_ch.total_priority)
);
